### rtl/core/kps_pkg.sv
// Shared types and constants for the k nearest points select unit.
package kps_pkg;

   localparam int COORD_W    = 16;
   localparam int DIST_W     = 32;
   localparam int WANT_W     = 7;
   localparam int RESULT_CAP = 64;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      last_point;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] near_x;
      logic signed [COORD_W-1:0] near_y;
      logic                      last_result;
      logic                      points_dropped;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_FLUSH
   } state_type;

endpackage

### rtl/core/kps_store.sv
// Point memory: one write port, one registered read port.
module kps_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  kps_pkg::point_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output kps_pkg::point_type  rd_data
);

   kps_pkg::point_type mem [DEPTH];
   kps_pkg::point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/kps_dist.sv
// Squared-distance pipeline with eligibility check against the previous pick.
module kps_dist #(
   parameter int AW = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  kps_pkg::point_type          in_point,
   input  logic [AW-1:0]               in_idx,
   input  logic                        has_prev,
   input  logic [kps_pkg::DIST_W-1:0]  prev_dist,
   input  logic [AW-1:0]               prev_idx,
   output logic                        out_valid,
   output kps_pkg::point_type          out_point,
   output logic [AW-1:0]               out_idx,
   output logic [kps_pkg::DIST_W-1:0]  out_dist,
   output logic                        out_elig,
   output logic                        busy
);

   localparam int SQ_W = kps_pkg::DIST_W - 1;

   logic signed [2*kps_pkg::COORD_W-1:0] prod_x;
   logic signed [2*kps_pkg::COORD_W-1:0] prod_y;

   logic                       v1_ff, v2_ff, v3_ff;
   kps_pkg::point_type         p1_ff, p2_ff, p3_ff;
   logic [AW-1:0]              i1_ff, i2_ff, i3_ff;
   logic [SQ_W-1:0]            sqx_ff, sqy_ff;
   logic [kps_pkg::DIST_W-1:0] d2_ff, d3_ff;
   logic                       elig_ff;
   logic                       elig_in;

   assign prod_x = in_point.x * in_point.x;
   assign prod_y = in_point.y * in_point.y;

   assign elig_in = !has_prev || (d2_ff > prev_dist) ||
                    ((d2_ff == prev_dist) && (i2_ff > prev_idx));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      sqx_ff  <= prod_x[SQ_W-1:0];
      sqy_ff  <= prod_y[SQ_W-1:0];
      p1_ff   <= in_point;
      i1_ff   <= in_idx;
      d2_ff   <= kps_pkg::DIST_W'(sqx_ff) + kps_pkg::DIST_W'(sqy_ff);
      p2_ff   <= p1_ff;
      i2_ff   <= i1_ff;
      d3_ff   <= d2_ff;
      p3_ff   <= p2_ff;
      i3_ff   <= i2_ff;
      elig_ff <= elig_in;
   end

   assign out_valid = v3_ff;
   assign out_point = p3_ff;
   assign out_idx   = i3_ff;
   assign out_dist  = d3_ff;
   assign out_elig  = elig_ff;
   assign busy      = v1_ff | v2_ff | v3_ff;

endmodule

### rtl/core/k_nearest_points_select_unit.sv
// Top level of the k nearest points select unit: load control, selection rounds, result register.
// Points are loaded one per cycle into an on-chip memory of MAX_POINTS entries; points beyond
// that are dropped and flagged on every result of the set. After the point marked last, req_stall
// stays high while the unit picks min(neighbours_wanted, 64, points held) results in ascending
// squared distance, earlier arrival first on ties. Each result takes one full pass over the N held
// points through the single memory read port and a three-stage distance pipeline. Results leave
// through an output register, and the next set may start loading while the final result still
// waits to be taken. Write neighbours_wanted only while idle.
module k_nearest_points_select_unit #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  kps_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output kps_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [kps_pkg::WANT_W-1:0]  csr_data
);

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int CMPW = (CW > kps_pkg::WANT_W) ? CW : kps_pkg::WANT_W;
   localparam int WW   = kps_pkg::WANT_W;

   kps_pkg::state_type state_ff, state_in;

   logic [WW-1:0]              wanted_ff, want_sat;
   logic [CW-1:0]              count_ff, count_in, count_next;
   logic                       ovf_ff, ovf_in, ovf_next;
   logic [WW-1:0]              emit_ff, emit_in, emit_next;
   logic [WW-1:0]              rounds_ff, rounds_in;
   logic [AW-1:0]              rd_addr_ff, rd_addr_in;
   logic                       rd_valid_ff;
   logic [AW-1:0]              rd_idx_ff;
   logic                       has_prev_ff, has_prev_in;
   logic [kps_pkg::DIST_W-1:0] prev_dist_ff, prev_dist_in;
   logic [AW-1:0]              prev_idx_ff, prev_idx_in;
   logic                       best_found_ff, best_found_in;
   logic [kps_pkg::DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [AW-1:0]              best_idx_ff, best_idx_in;
   kps_pkg::point_type         best_pt_ff, best_pt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   kps_pkg::rsp_type           rsp_data_ff;

   logic                       store_full, accept, issue, last_addr, pipe_empty;
   logic                       slot_free, push, round_last, take_best;
   kps_pkg::point_type         wr_point, rd_point;
   kps_pkg::point_type         d_point;
   logic                       d_valid, d_elig, d_busy;
   logic [AW-1:0]              d_idx;
   logic [kps_pkg::DIST_W-1:0] d_dist;

   assign csr_ready = 1'b1;

   assign store_full = (count_ff == CW'(MAX_POINTS));
   assign count_next = store_full ? count_ff : count_ff + CW'(1);
   assign ovf_next   = ovf_ff | store_full;
   assign want_sat   = (wanted_ff > WW'(kps_pkg::RESULT_CAP)) ?
                       WW'(kps_pkg::RESULT_CAP) : wanted_ff;
   assign emit_next  = (CMPW'(count_next) < CMPW'(want_sat)) ? WW'(count_next) : want_sat;
   assign last_addr  = ((CW'(rd_addr_ff) + CW'(1)) == count_ff);
   assign pipe_empty = !rd_valid_ff && !d_busy;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign round_last = ((rounds_ff + WW'(1)) == emit_ff);
   assign take_best  = d_valid && d_elig && (!best_found_ff || (d_dist < best_dist_ff));

   assign wr_point.x = req_data.point_x;
   assign wr_point.y = req_data.point_y;

   kps_store #(
      .DEPTH (MAX_POINTS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && !store_full),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_point),
      .rd_en   (issue),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_point)
   );

   kps_dist #(
      .AW (AW)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .in_point  (rd_point),
      .in_idx    (rd_idx_ff),
      .has_prev  (has_prev_ff),
      .prev_dist (prev_dist_ff),
      .prev_idx  (prev_idx_ff),
      .out_valid (d_valid),
      .out_point (d_point),
      .out_idx   (d_idx),
      .out_dist  (d_dist),
      .out_elig  (d_elig),
      .busy      (d_busy)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kps_pkg::ST_LOAD: begin
            if (accept && req_data.last_point && (emit_next != '0)) begin
               state_in = kps_pkg::ST_SCAN;
            end
         end
         kps_pkg::ST_SCAN: begin
            if (last_addr) begin
               state_in = kps_pkg::ST_FLUSH;
            end
         end
         kps_pkg::ST_FLUSH: begin
            if (push) begin
               state_in = round_last ? kps_pkg::ST_LOAD : kps_pkg::ST_SCAN;
            end
         end
         default: state_in = kps_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != kps_pkg::ST_LOAD);
      issue     = (state_ff == kps_pkg::ST_SCAN);
      push      = (state_ff == kps_pkg::ST_FLUSH) && pipe_empty && slot_free;
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      emit_in       = emit_ff;
      rounds_in     = rounds_ff;
      rd_addr_in    = rd_addr_ff;
      has_prev_in   = has_prev_ff;
      prev_dist_in  = prev_dist_ff;
      prev_idx_in   = prev_idx_ff;
      best_found_in = best_found_ff;
      best_dist_in  = best_dist_ff;
      best_idx_in   = best_idx_ff;
      best_pt_in    = best_pt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (accept) begin
         if (req_data.last_point && (emit_next == '0)) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            count_in = count_next;
            ovf_in   = ovf_next;
         end
         if (req_data.last_point) begin
            emit_in       = emit_next;
            rounds_in     = '0;
            rd_addr_in    = '0;
            has_prev_in   = 1'b0;
            best_found_in = 1'b0;
         end
      end

      if (issue) begin
         rd_addr_in = rd_addr_ff + AW'(1);
      end

      if (take_best) begin
         best_found_in = 1'b1;
         best_dist_in  = d_dist;
         best_idx_in   = d_idx;
         best_pt_in    = d_point;
      end

      if (push) begin
         rsp_valid_in  = 1'b1;
         rounds_in     = rounds_ff + WW'(1);
         rd_addr_in    = '0;
         has_prev_in   = 1'b1;
         prev_dist_in  = best_dist_ff;
         prev_idx_in   = best_idx_ff;
         best_found_in = 1'b0;
         if (round_last) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kps_pkg::ST_LOAD;
         wanted_ff     <= WW'(1);
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         emit_ff       <= '0;
         rounds_ff     <= '0;
         rd_addr_ff    <= '0;
         rd_valid_ff   <= 1'b0;
         has_prev_ff   <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_valid && csr_ready) begin
            wanted_ff <= csr_data;
         end
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         emit_ff       <= emit_in;
         rounds_ff     <= rounds_in;
         rd_addr_ff    <= rd_addr_in;
         rd_valid_ff   <= issue;
         has_prev_ff   <= has_prev_in;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_addr_ff;
      prev_dist_ff <= prev_dist_in;
      prev_idx_ff  <= prev_idx_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      best_pt_ff   <= best_pt_in;
      if (push) begin
         rsp_data_ff.near_x         <= best_pt_ff.x;
         rsp_data_ff.near_y         <= best_pt_ff.y;
         rsp_data_ff.last_result    <= round_last;
         rsp_data_ff.points_dropped <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_push_has_pick: assert property (@(posedge clock) disable iff (reset)
      push |-> best_found_ff)
      else $error("result pushed without a selected point");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count beyond capacity");

   a_rounds_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != kps_pkg::ST_LOAD) |-> (rounds_ff < emit_ff))
      else $error("selection round count past result count");

   a_set_end: assert property (@(posedge clock) disable iff (reset)
      (push && round_last) |=> ((state_ff == kps_pkg::ST_LOAD) && (count_ff == '0)))
      else $error("set not cleared after final result");

endmodule
